// File: hdl/lcr_pkg.sv
// Shared types and constants for the load cell converter reader.
package lcr_pkg;

  // Magnitude of (raw - zero): raw and zero both fit 33 signed bits.
  localparam int unsigned DIFF_W = 34;
  localparam int unsigned MAG_W  = 33;
  localparam int unsigned GAIN_W = 32;
  localparam int unsigned TMO_W  = 24;
  localparam int unsigned DG_W   = 16;
  localparam int unsigned CNT_W  = 4;
  localparam int unsigned TARE_SAMPLES = 8;
  localparam int unsigned DG_LIMIT     = 32000;
  localparam logic [TMO_W-1:0] TMO_RESET = 24'd500000;

  typedef enum logic [1:0] {
    CFG_ZERO_OFFSET = 2'd0,
    CFG_GAIN_Q16    = 2'd1,
    CFG_TARE_TMO    = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    MODE_IDLE  = 1'b0,
    MODE_SHIFT = 1'b1
  } mode_e;

  // First stage result, carried to the scaling stage.
  typedef struct packed {
    logic             sck;
    logic             fresh;
    logic             done;
    logic             timed_out;
    logic             taring;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } stage_t;

endpackage

// File: hdl/lcr_scale.sv
// Gain multiply, truncation and saturation of one reading magnitude.
module lcr_scale (
  input  logic [lcr_pkg::MAG_W-1:0]  mag_i,
  input  logic                       neg_i,
  input  logic [lcr_pkg::GAIN_W-1:0] gain_i,
  output logic signed [lcr_pkg::DG_W-1:0] reading_o
);
  import lcr_pkg::*;

  logic [63:0]     prod;
  logic [47:0]     quot;
  logic            sat;
  logic [DG_W-1:0] mag_dg;

  assign prod   = 64'(mag_i[31:0]) * 64'(gain_i);
  assign quot   = prod[63:16];
  // zero gain always reads 0; otherwise magnitudes of 2^32 or more, or scaled values above DG_LIMIT, saturate
  assign sat    = (gain_i != '0) & (mag_i[MAG_W-1] | (quot > 48'(DG_LIMIT)));
  assign mag_dg = sat ? DG_W'(DG_LIMIT) : quot[DG_W-1:0];

  always_comb begin
    if (neg_i) begin
      reading_o = -$signed(mag_dg);
    end else begin
      reading_o = $signed(mag_dg);
    end
  end

endmodule

// File: hdl/load_cell_adc_reader_with_tare.sv
// Top level: serial load cell converter reader with tare averaging and scaling.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------------
//  in       | in_valid_i / in_ready_o   | action_i, dout_level_i
//  out      | out_valid_o / out_ready_i | sck_level_o, weight_dg_o, new_reading_o,
//           |                           | tare_done_o, tare_timed_out_o, taring_o
//  cfg      | cfg_we_i (no wait)        | cfg_index_i, cfg_data_i
//
// One item per cycle while the output is not stalled; each result is registered
// in stage one and then in the output register before it is valid on the outputs.
// Stage one updates the bit shifter and tare state, stage two runs the gain
// multiply and loads the output register. Both stages advance together and
// hold while the output is stalled. Reset clears all but the stage-one payload,
// sets gain to 0 and tare timeout to 500000 ticks; no clearing pass is needed.
module load_cell_adc_reader_with_tare #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic               dout_level_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               sck_level_o,
  output logic signed [15:0] weight_dg_o,
  output logic               new_reading_o,
  output logic               tare_done_o,
  output logic               tare_timed_out_o,
  output logic               taring_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import lcr_pkg::*;

  localparam int unsigned ZP_W  = (SAMPLE_BITS > 24) ? SAMPLE_BITS : 24;
  localparam int unsigned SUM_W = SAMPLE_BITS + 3;
  localparam int unsigned PC_W  = $clog2(SAMPLE_BITS + 2);

  logic                    adv;
  logic                    in_xfer;

  mode_e                   mode_q, mode_d;
  logic [PC_W-1:0]         pc_q, pc_d;
  logic                    ch_q, ch_d;
  logic [SAMPLE_BITS-1:0]  shift_q, shift_d;
  logic signed [ZP_W-1:0]  zp_q, zp_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [TMO_W-1:0]        wait_q, wait_d;
  logic                    pend_q, pend_d;
  logic [GAIN_W-1:0]       gain_q;
  logic [TMO_W-1:0]        tmo_q;

  stage_t                  s1_q, s1_d;
  logic                    s1_valid_q;

  logic                    out_valid_q;
  logic                    out_sck_q, out_fresh_q, out_done_q, out_to_q, out_taring_q;
  logic signed [DG_W-1:0]  held_q;
  logic signed [DG_W-1:0]  scaled;

  logic signed [SUM_W-1:0]  raw_sum;
  logic signed [SUM_W-1:0]  sum_new;
  logic signed [SUM_W-1:0]  sum_adj;
  logic signed [SUM_W-1:0]  avg;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_abs;

  // whole pipeline moves when the output register is free or being drained
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign in_xfer    = in_valid_i && adv;

  assign raw_sum  = $signed({{3{shift_q[SAMPLE_BITS-1]}}, shift_q});
  assign sum_new  = sum_q + raw_sum;
  // truncate toward zero: bias negatives before the shift
  assign sum_adj  = sum_new + (sum_new[SUM_W-1] ? SUM_W'(TARE_SAMPLES - 1) : '0);
  assign avg      = sum_adj >>> $clog2(TARE_SAMPLES);
  assign diff     = $signed({{(DIFF_W-SAMPLE_BITS){shift_q[SAMPLE_BITS-1]}}, shift_q})
                  - $signed({{(DIFF_W-ZP_W){zp_q[ZP_W-1]}}, zp_q});
  assign diff_abs = diff[DIFF_W-1] ? -diff : diff;

  always_comb begin
    mode_d  = mode_q;
    pc_d    = pc_q;
    ch_d    = ch_q;
    shift_d = shift_q;
    zp_d    = zp_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    wait_d  = wait_q;
    pend_d  = pend_q;
    s1_d    = '0;
    if (action_i) begin
      pend_d = 1'b1;
      sum_d  = '0;
      cnt_d  = '0;
      wait_d = '0;
    end else if (mode_q == MODE_IDLE) begin
      if (!dout_level_i) begin
        mode_d  = MODE_SHIFT;
        shift_d = '0;
        pc_d    = PC_W'(1);
        ch_d    = 1'b1;
      end else if (pend_q) begin
        if (wait_q >= tmo_q) begin
          pend_d          = 1'b0;
          sum_d           = '0;
          cnt_d           = '0;
          wait_d          = '0;
          s1_d.timed_out  = 1'b1;
        end else begin
          wait_d = wait_q + 1'b1;
        end
      end
    end else if (ch_q) begin
      if (pc_q <= PC_W'(SAMPLE_BITS)) begin
        shift_d = {shift_q[SAMPLE_BITS-2:0], dout_level_i};
      end
      ch_d = 1'b0;
      // the gain-select pulse ends the conversion; no shift on that pulse
      if (pc_q >= PC_W'(SAMPLE_BITS + 1)) begin
        mode_d = MODE_IDLE;
        pc_d   = '0;
        if (pend_q) begin
          sum_d  = sum_new;
          cnt_d  = cnt_q + 1'b1;
          wait_d = '0;
          if (cnt_q == CNT_W'(TARE_SAMPLES - 1)) begin
            zp_d      = ZP_W'(avg);
            pend_d    = 1'b0;
            sum_d     = '0;
            cnt_d     = '0;
            s1_d.done = 1'b1;
          end
        end else begin
          s1_d.fresh = 1'b1;
          s1_d.neg   = diff[DIFF_W-1];
          s1_d.mag   = diff_abs[MAG_W-1:0];
        end
      end
    end else begin
      pc_d = pc_q + 1'b1;
      ch_d = 1'b1;
    end
    s1_d.sck    = ch_d;
    s1_d.taring = pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pc_q    <= '0;
      ch_q    <= 1'b0;
      shift_q <= '0;
      zp_q    <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
      wait_q  <= '0;
      pend_q  <= 1'b0;
      gain_q  <= '0;
      tmo_q   <= TMO_RESET;
    end else begin
      if (in_xfer) begin
        mode_q  <= mode_d;
        pc_q    <= pc_d;
        ch_q    <= ch_d;
        shift_q <= shift_d;
        zp_q    <= zp_d;
        sum_q   <= sum_d;
        cnt_q   <= cnt_d;
        wait_q  <= wait_d;
        pend_q  <= pend_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_ZERO_OFFSET: zp_q   <= ZP_W'($signed(cfg_data_i[23:0]));
          CFG_GAIN_Q16:    gain_q <= cfg_data_i;
          CFG_TARE_TMO:    tmo_q  <= cfg_data_i[TMO_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= s1_d;
    end
  end

  lcr_scale u_scale (
    .mag_i     (s1_q.mag),
    .neg_i     (s1_q.neg),
    .gain_i    (gain_q),
    .reading_o (scaled)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_sck_q    <= 1'b0;
      out_fresh_q  <= 1'b0;
      out_done_q   <= 1'b0;
      out_to_q     <= 1'b0;
      out_taring_q <= 1'b0;
      held_q       <= '0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        out_sck_q    <= s1_q.sck;
        out_fresh_q  <= s1_q.fresh;
        out_done_q   <= s1_q.done;
        out_to_q     <= s1_q.timed_out;
        out_taring_q <= s1_q.taring;
        if (s1_q.fresh) begin
          held_q <= scaled;
        end
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sck_level_o      = out_sck_q;
  assign weight_dg_o      = held_q;
  assign new_reading_o    = out_fresh_q;
  assign tare_done_o      = out_done_q;
  assign tare_timed_out_o = out_to_q;
  assign taring_o         = out_taring_q;

endmodule
